[rtl/modular_exponentiation_defines.svh]
// Assertion macros shared by the modular exponentiation RTL.
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define MEXP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Implication checked on every clock edge outside reset.
`define MEXP_ASSERT_IMP(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

`endif

[rtl/mexp_pkg.sv]
// Types and constants for the modular exponentiation block.
`timescale 1ns / 1ps
package mexp_pkg;

    localparam int DATA_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int STEP_W    = $clog2(DATA_W);

    typedef logic [DATA_W-1:0]    t_word;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [STEP_W-1:0]    t_step;

    localparam t_cfg_idx CFG_EXPONENT = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_MODULUS  = t_cfg_idx'(1);

    localparam t_step STEP_LAST = t_step'(DATA_W - 1);

endpackage

[rtl/modular_exponentiation.sv]
// Modular exponentiation top level: base^exponent mod modulus, square and multiply.
`timescale 1ns / 1ps
`include "modular_exponentiation_defines.svh"
// Usage:
//   Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
//   (0 = exponent, 1 = modulus). A zero modulus write is dropped. Write only
//   while the block is idle.
//   Input stream: one 32-bit base word per transfer on the s_axis side.
//   Output stream: one 32-bit result word per input on the m_axis side.
//   Exponent bits are scanned from bit WIDTH-1 down to 0. Each modular product
//   uses one 32x32 multiply and a bit-serial restoring reduction on the
//   single shared reduction unit. The base is first reduced the same way.
//   A zero exponent yields 1 without any multiply or reduction. One word is
//   processed at a time; o_s_axis_tready is high only while the sequencer
//   is idle.
//   The result sits in an output register; the next base may be accepted
//   while it waits. If the receiver stalls, a finished result waits in the
//   sequencer until the output register frees up.
//   Reset (synchronous, active low) sets exponent 0, modulus 1, and empties
//   the pipeline.
module modular_exponentiation #(
    parameter int WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  mexp_pkg::t_cfg_idx i_cfg_index,
    input  mexp_pkg::t_word    i_cfg_data,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  mexp_pkg::t_word    i_s_axis_tdata,   // [31:0] base_value
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output mexp_pkg::t_word    o_m_axis_tdata    // [31:0] power_result
);
    import mexp_pkg::*;

    localparam int BIT_W = $clog2(WIDTH);

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_RED, S_DONE} t_state;
    typedef enum logic [1:0] {PH_BASE, PH_SQ, PH_MUL} t_phase;

    t_state             r_state;
    t_phase             r_phase;
    t_word              r_exponent;
    t_word              r_modulus;
    t_word              r_acc;
    t_word              r_base;
    t_word              r_rem;
    t_word              r_low;
    t_word              r_result;
    t_step              r_cnt;
    logic [BIT_W-1:0]   r_bit;
    logic               r_out_valid;

    logic [DATA_W:0]    w_trial;
    logic               w_ge;
    t_word              w_red;
    t_word              w_mul_b;
    logic [2*DATA_W-1:0] w_prod;
    logic               w_exp_zero;
    logic               w_in_acc;

    assign w_trial    = {r_rem, r_low[DATA_W-1]};
    assign w_ge       = w_trial >= {1'b0, r_modulus};
    assign w_red      = w_ge ? DATA_W'(w_trial - {1'b0, r_modulus}) : DATA_W'(w_trial);
    assign w_mul_b    = (r_phase == PH_MUL) ? r_base : r_acc;
    assign w_prod     = (2*DATA_W)'(r_acc) * (2*DATA_W)'(w_mul_b);
    assign w_exp_zero = (r_exponent[WIDTH-1:0] == '0);
    assign w_in_acc   = i_s_axis_tvalid && o_s_axis_tready;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_BASE;
            r_exponent  <= '0;
            r_modulus   <= t_word'(1);
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_bit       <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_EXPONENT: r_exponent <= i_cfg_data;
                    CFG_MODULUS: begin
                        if (i_cfg_data != '0) r_modulus <= i_cfg_data;
                    end
                    default: ;
                endcase
            end
            if (r_out_valid && i_m_axis_tready && r_state != S_DONE) r_out_valid <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (w_exp_zero) begin
                            r_acc   <= t_word'(1);
                            r_state <= S_DONE;
                        end else begin
                            r_low   <= i_s_axis_tdata;
                            r_rem   <= '0;
                            r_cnt   <= '0;
                            r_phase <= PH_BASE;
                            r_state <= S_RED;
                        end
                    end
                end
                S_MUL: begin
                    r_rem   <= w_prod[2*DATA_W-1:DATA_W];
                    r_low   <= w_prod[DATA_W-1:0];
                    r_cnt   <= '0;
                    r_state <= S_RED;
                end
                S_RED: begin
                    r_rem <= w_red;
                    r_low <= {r_low[DATA_W-2:0], 1'b0};
                    r_cnt <= r_cnt + t_step'(1);
                    if (r_cnt == STEP_LAST) begin
                        case (r_phase)
                            PH_BASE: begin
                                r_base  <= w_red;
                                r_acc   <= t_word'(1);
                                r_bit   <= BIT_W'(WIDTH - 1);
                                r_phase <= PH_SQ;
                                r_state <= S_MUL;
                            end
                            default: begin
                                r_acc <= w_red;
                                if (r_phase == PH_SQ && r_exponent[r_bit]) begin
                                    r_phase <= PH_MUL;
                                    r_state <= S_MUL;
                                end else if (r_bit == '0) begin
                                    r_state <= S_DONE;
                                end else begin
                                    r_bit   <= r_bit - BIT_W'(1);
                                    r_phase <= PH_SQ;
                                    r_state <= S_MUL;
                                end
                            end
                        endcase
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_result    <= r_acc;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `MEXP_ASSERT(a_mod_nonzero, r_modulus != '0, "modulus register became zero")
    `MEXP_ASSERT_IMP(a_rem_below_mod, r_state == S_RED, r_rem < r_modulus,
        "partial remainder not below modulus")
    `MEXP_ASSERT_IMP(a_acc_reduced, r_state == S_MUL,
        (r_acc < r_modulus) || (r_acc == t_word'(1)), "accumulator not reduced")
    `MEXP_ASSERT_IMP(a_busy_after_accept, w_in_acc, ##1 !o_s_axis_tready,
        "ready high right after an accepted word")

endmodule
